FILE: rtl/rcsc_pkg.sv
// Shared types, constants and helper functions for the colour space converter.
package rcsc_pkg;

  localparam int FRAC_BITS = 10;
  localparam int IN_W      = 8;
  localparam int MODE_W    = 4;
  localparam int OUT_W     = 21;
  localparam int QB        = OUT_W;
  localparam int NUM_W     = 37;
  localparam int DEN_W     = 27;
  localparam int COEF_W    = 28;
  localparam int X_W       = 10;
  localparam int SQ_W      = 16;
  localparam int CHAN_LAT  = QB + 2;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS   = 4'd0,
    MODE_CHROMA = 4'd1,
    MODE_RGBII  = 4'd2,
    MODE_XYZII  = 4'd3,
    MODE_OPP    = 4'd4,
    MODE_I3     = 4'd5,
    MODE_LSLM   = 4'd6,
    MODE_ZRG    = 4'd7,
    MODE_L3     = 4'd8
  } mode_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } chan_req_t;

  typedef struct packed {
    chan_req_t [2:0] ch;
    logic            opp;
  } req_t;

  // opponent mode: q ~ (m * C + half) >> OPP_P with C = 2^(FRAC+OPP_P) / sqrt(k)
  localparam int OPP_P   = 31 - FRAC_BITS;
  localparam int OPP_M_W = 10;
  localparam int OPP_C_W = 32;
  localparam int OPP_Q_W = OPP_M_W + FRAC_BITS;

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned cand;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  localparam longint unsigned OPP_T2 = (64'd1 << 62) / 2;
  localparam longint unsigned OPP_T6 = (64'd1 << 62) / 6;
  localparam longint unsigned OPP_T3 = (64'd1 << 62) / 3;
  localparam logic [OPP_C_W-1:0] OPP_C2 = OPP_C_W'(isqrt(OPP_T2));
  localparam logic [OPP_C_W-1:0] OPP_C6 = OPP_C_W'(isqrt(OPP_T6));
  localparam logic [OPP_C_W-1:0] OPP_C3 = OPP_C_W'(isqrt(OPP_T3));

  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;
  localparam logic [1:0] CH_C = 2'd2;

endpackage

FILE: rtl/rcsc_front.sv
// Front end: mode register, coefficient products and numerator/denominator build.
module rcsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data,
  output logic                  push,
  output rcsc_pkg::req_t        req
);
  import rcsc_pkg::*;

  localparam logic [DEN_W-1:0] D_ONE  = DEN_W'(1);
  localparam logic [DEN_W-1:0] D_TWO  = DEN_W'(2);
  localparam logic [DEN_W-1:0] D_THR  = DEN_W'(3);
  localparam logic [DEN_W-1:0] D_2K   = DEN_W'(2000);
  localparam logic [DEN_W-1:0] D_10K  = DEN_W'(10000);
  localparam logic [DEN_W-1:0] D_100M = DEN_W'(100000000);

  mode_t mode;
  mode_t mode1;
  logic  v1;

  logic signed [COEF_W-1:0]      coef [3][3];
  logic signed [X_W-1:0]         xs   [3];
  logic signed [COEF_W+X_W-1:0]  pf   [3][3];
  logic signed [8:0]             dif  [3];
  logic signed [17:0]            sqf  [3];

  logic signed [NUM_W-1:0] p1  [3][3];
  logic [SQ_W-1:0]         sq1 [3];
  logic [9:0]              s1;

  logic [DEN_W-1:0]        den [3];
  logic [SQ_W+1:0]         s2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PASS;
    end else if (cfg_valid) begin
      mode <= mode_t'(cfg_data);
    end
  end

  always_comb begin
    coef = '{default: '0};
    case (mode)
      MODE_PASS, MODE_CHROMA: coef = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
      MODE_RGBII: coef = '{'{1, 0, 0}, '{-5774, 7887, -2113}, '{-5774, -2113, 7887}};
      MODE_XYZII: coef = '{'{6070, 1740, 2000}, '{-901, 3631, -2730},
                           '{-4600, -1986, 6586}};
      MODE_OPP:   coef = '{'{1, -1, 0}, '{1, 1, -2}, '{1, 1, 1}};
      MODE_I3:    coef = '{'{1, 1, 1}, '{1, 0, -1}, '{-1, 2, -1}};
      MODE_LSLM:  coef = '{'{209, 715, 76}, '{209, 715, -924}, '{3148, -2799, -349}};
      MODE_ZRG:   coef = '{'{2018311, 12955342, 93918125}, '{1, 0, 0}, '{0, 1, 0}};
      default:    coef = '{default: '0};
    endcase
  end

  // LSLM works on 2x-1, i.e. twice the half-offset value
  always_comb begin
    if (mode == MODE_LSLM) begin
      xs[0] = signed'({1'b0, red, 1'b0}) - 10'sd1;
      xs[1] = signed'({1'b0, green, 1'b0}) - 10'sd1;
      xs[2] = signed'({1'b0, blue, 1'b0}) - 10'sd1;
    end else begin
      xs[0] = signed'({2'b00, red});
      xs[1] = signed'({2'b00, green});
      xs[2] = signed'({2'b00, blue});
    end
    dif[0] = signed'({1'b0, red})   - signed'({1'b0, green});
    dif[1] = signed'({1'b0, red})   - signed'({1'b0, blue});
    dif[2] = signed'({1'b0, green}) - signed'({1'b0, blue});
    for (int c = 0; c < 3; c++) begin
      sqf[c] = dif[c] * dif[c];
      for (int j = 0; j < 3; j++) begin
        pf[c][j] = coef[c][j] * xs[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mode1 <= mode;
    s1    <= 10'(red) + 10'(green) + 10'(blue);
    for (int c = 0; c < 3; c++) begin
      sq1[c] <= sqf[c][SQ_W-1:0];
      for (int j = 0; j < 3; j++) begin
        p1[c][j] <= pf[c][j][NUM_W-1:0];
      end
    end
  end

  assign s2 = (SQ_W+2)'(sq1[0]) + (SQ_W+2)'(sq1[1]) + (SQ_W+2)'(sq1[2]);

  always_comb begin
    den = '{default: D_ONE};
    case (mode1)
      MODE_PASS:   den = '{D_ONE, D_ONE, D_ONE};
      MODE_CHROMA: den = '{default: (s1 == '0) ? D_ONE : DEN_W'(s1)};
      MODE_RGBII:  den = '{D_ONE, D_10K, D_10K};
      MODE_XYZII:  den = '{D_10K, D_10K, D_10K};
      MODE_OPP:    den = '{D_ONE, D_ONE, D_ONE};
      MODE_I3:     den = '{D_THR, D_TWO, D_TWO};
      MODE_LSLM:   den = '{D_2K, D_2K, D_2K};
      MODE_ZRG:    den = '{D_100M, D_ONE, D_ONE};
      MODE_L3:     den = '{default: (s2 == '0) ? D_ONE : DEN_W'(s2)};
      default:     den = '{D_ONE, D_ONE, D_ONE};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v1;
    end
  end

  always_ff @(posedge clk) begin
    req.opp <= (mode1 == MODE_OPP);
    for (int c = 0; c < 3; c++) begin
      req.ch[c].den <= den[c];
      if (mode1 == MODE_L3) begin
        req.ch[c].num <= signed'(NUM_W'(sq1[c]));
      end else begin
        req.ch[c].num <= p1[c][0] + p1[c][1] + p1[c][2];
      end
    end
  end

endmodule

FILE: rtl/rcsc_queue.sv
// Two-entry request queue between the front end and the channel units.
module rcsc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcsc_pkg::req_t  wdata,
  input  logic            pop,
  output rcsc_pkg::req_t  rdata,
  output logic            nonempty,
  output logic            full
);
  import rcsc_pkg::*;

  req_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_pop;

  assign do_pop   = pop && (count != 2'd0);
  assign nonempty = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign rdata    = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + 2'(push && !full) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) entry[wptr] <= wdata;
  end

  assert property (@(posedge clk) disable iff (rst) push |=> nonempty)
    else $error("request lost on push");
  assert property (@(posedge clk) disable iff (rst) (full && !pop) |=> full)
    else $error("queue drained without pop");
  assert property (@(posedge clk) disable iff (rst) !(count == 2'd3))
    else $error("queue count out of range");

endmodule

FILE: rtl/rcsc_chan.sv
// Channel unit: pipelined rounding divider plus exact opponent-mode scaler.
module rcsc_chan (
  input  logic                               clk,
  input  logic [1:0]                         sel,
  input  logic                               opp,
  input  rcsc_pkg::chan_req_t                req,
  output logic signed [rcsc_pkg::OUT_W-1:0]  value
);
  import rcsc_pkg::*;

  localparam int REM_W = NUM_W + FRAC_BITS + 2;
  localparam int DSH_W = DEN_W + 1 + QB;
  localparam int CMP_W = (REM_W > DSH_W) ? REM_W : DSH_W;
  localparam int T_W   = OPP_Q_W + 1;
  localparam int LO_W  = 2 * T_W + 3;
  localparam int RH_W  = 2 * OPP_M_W + 2 * FRAC_BITS + 2;
  localparam int SC_W  = (LO_W > RH_W) ? LO_W : RH_W;
  localparam int MAG_W = ((OPP_Q_W > QB) ? OPP_Q_W : QB) + 1;

  logic                 neg;
  logic [NUM_W-1:0]     mag;
  logic [CMP_W-1:0]     nn;
  logic [CMP_W-1:0]     dd;
  logic [OPP_C_W-1:0]   cval;
  logic [2:0]           kval;
  logic [OPP_M_W-1:0]   sm;
  logic [OPP_M_W+OPP_C_W-1:0] qprod;

  logic [CMP_W-1:0] rem [QB+1];
  logic [CMP_W-1:0] dv  [QB+1];
  logic [QB-1:0]    quo [QB+1];
  logic             ng  [QB+1];
  logic             ov  [QB+1];
  logic             op  [QB+1];

  logic [OPP_Q_W-1:0] q0;
  logic [OPP_M_W-1:0] m0;
  logic [OPP_Q_W-1:0] q1;
  logic [SC_W-1:0]    lo1;
  logic [SC_W-1:0]    hi1;
  logic [SC_W-1:0]    rh1;
  logic [T_W-1:0]     tlo;
  logic [T_W-1:0]     thi;
  logic [OPP_Q_W-1:0] sqp [2:QB];

  logic [MAG_W-1:0]   fmag;

  always_comb begin
    case (sel)
      CH_A:    begin cval = OPP_C2; kval = 3'd2; end
      CH_B:    begin cval = OPP_C6; kval = 3'd6; end
      default: begin cval = OPP_C3; kval = 3'd3; end
    endcase
  end

  assign neg   = req.num[NUM_W-1];
  assign mag   = neg ? NUM_W'(-req.num) : NUM_W'(req.num);
  assign nn    = (CMP_W'(mag) << (FRAC_BITS + 1)) + CMP_W'(req.den);
  assign dd    = CMP_W'(req.den) << 1;
  assign sm    = mag[OPP_M_W-1:0];
  assign qprod = (OPP_M_W+OPP_C_W)'(sm) * (OPP_M_W+OPP_C_W)'(cval);

  always_ff @(posedge clk) begin
    rem[0] <= nn;
    dv[0]  <= dd;
    quo[0] <= '0;
    ng[0]  <= neg;
    ov[0]  <= (nn >= (dd << QB));
    op[0]  <= opp;
    q0     <= OPP_Q_W'((qprod + ((OPP_M_W+OPP_C_W)'(1) << (OPP_P - 1))) >> OPP_P);
    m0     <= sm;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int BI = QB - 1 - s;
    logic [CMP_W-1:0] trial;
    assign trial = dv[s] << BI;
    always_ff @(posedge clk) begin
      dv[s+1] <= dv[s];
      ng[s+1] <= ng[s];
      ov[s+1] <= ov[s];
      op[s+1] <= op[s];
      if (rem[s] >= trial) begin
        rem[s+1] <= rem[s] - trial;
        quo[s+1] <= quo[s] | (QB'(1) << BI);
      end else begin
        rem[s+1] <= rem[s];
        quo[s+1] <= quo[s];
      end
    end
  end

  // bracket check: k(2q-1)^2 < 4 m^2 4^F < k(2q+1)^2
  assign tlo = {q0, 1'b0} - T_W'(1);
  assign thi = {q0, 1'b0} + T_W'(1);

  always_ff @(posedge clk) begin
    q1  <= q0;
    lo1 <= SC_W'(kval) * (SC_W'(tlo) * SC_W'(tlo));
    hi1 <= SC_W'(kval) * (SC_W'(thi) * SC_W'(thi));
    rh1 <= (SC_W'(m0) * SC_W'(m0)) << (2 * FRAC_BITS + 2);
  end

  always_ff @(posedge clk) begin
    if ((q1 != '0) && (lo1 > rh1)) begin
      sqp[2] <= q1 - OPP_Q_W'(1);
    end else if (hi1 < rh1) begin
      sqp[2] <= q1 + OPP_Q_W'(1);
    end else begin
      sqp[2] <= q1;
    end
    for (int i = 3; i <= QB; i++) sqp[i] <= sqp[i-1];
  end

  always_comb begin
    if (op[QB]) begin
      fmag = MAG_W'(sqp[QB]);
    end else if (ov[QB]) begin
      fmag = {MAG_W{1'b1}};
    end else begin
      fmag = MAG_W'(quo[QB]);
    end
  end

  always_ff @(posedge clk) begin
    if (!ng[QB]) begin
      value <= (fmag > MAG_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(fmag);
    end else begin
      value <= (fmag > (MAG_W'(1) << (OUT_W - 1))) ? OUT_MIN : OUT_W'(-fmag);
    end
  end

endmodule

FILE: rtl/rgb_color_space_converter_unit.sv
// Top level of the RGB colour space converter.
//
//  channel  signals                         direction  transfer
//  pixel    start busy red green blue       in         start & !busy
//  config   cfg_valid cfg_ready cfg_data    in         cfg_valid & cfg_ready
//  result   done chan_a chan_b chan_c       out        done, one cycle
//
// One pixel per clock; done rises together with the result, which passes through
// two front stages, the queue, the issue register, the 21-stage restoring divider
// and the output register.
// busy is high only in reset; the result side cannot stall, so the queue
// between front end and channel units never fills.
module rgb_color_space_converter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic signed [20:0] chan_a,
  output logic signed [20:0] chan_b,
  output logic signed [20:0] chan_c
);
  import rcsc_pkg::*;

  logic                push;
  req_t                fq_req;
  req_t                head;
  logic                nonempty;
  logic                full;
  logic [CHAN_LAT-1:0] vline;

  assign busy = rst || full;

  rcsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .req       (fq_req)
  );

  rcsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (fq_req),
    .pop      (nonempty),
    .rdata    (head),
    .nonempty (nonempty),
    .full     (full)
  );

  rcsc_chan u_chan_a (.clk(clk), .sel(CH_A), .opp(head.opp), .req(head.ch[0]),
                      .value(chan_a));
  rcsc_chan u_chan_b (.clk(clk), .sel(CH_B), .opp(head.opp), .req(head.ch[1]),
                      .value(chan_b));
  rcsc_chan u_chan_c (.clk(clk), .sel(CH_C), .opp(head.opp), .req(head.ch[2]),
                      .value(chan_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else begin
      vline <= {vline[CHAN_LAT-2:0], nonempty};
    end
  end

  assign done = vline[CHAN_LAT-1];

  assert property (@(posedge clk) disable iff (rst) !full)
    else $error("request queue filled");
  assert property (@(posedge clk) disable iff (rst) nonempty |=> vline[0])
    else $error("queued request not issued");
  assert property (@(posedge clk) disable iff (rst) push |=> !$past(full))
    else $error("push into full queue");

endmodule

FILE: bench/rcsc_checker.sv
// Checker for the colour space converter: predicts each pixel's channels and compares results.
module rcsc_checker
  import rcsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [IN_W-1:0]         red,
  input  logic [IN_W-1:0]         green,
  input  logic [IN_W-1:0]         blue,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [MODE_W-1:0]       cfg_data,
  input  logic                    done,
  input  logic signed [OUT_W-1:0] chan_a,
  input  logic signed [OUT_W-1:0] chan_b,
  input  logic signed [OUT_W-1:0] chan_c,
  output int                      errors,
  output int                      pending,
  output int                      results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [OUT_W-1:0] a;
    logic signed [OUT_W-1:0] b;
    logic signed [OUT_W-1:0] c;
  } chans_t;

  chans_t              expected_chans[$];
  logic [MODE_W-1:0]   cur_mode;

  function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
    if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
    if (v < longint'(OUT_MIN)) v = longint'(OUT_MIN);
    return OUT_W'(v);
  endfunction

  // n / d in fixed point, nearest, ties away from zero
  function automatic logic signed [OUT_W-1:0] ratio_fx(longint n, longint d);
    longint m;
    longint q;
    m = (n < 0 ? -n : n) << FRAC_BITS;
    q = (2 * m + d) / (2 * d);
    return clamp_out(n < 0 ? -q : q);
  endfunction

  function automatic longint root_floor(longint x);
    longint r;
    r = 0;
    for (int i = 31; i >= 0; i--)
      if ((r + (longint'(1) << i)) * (r + (longint'(1) << i)) <= x)
        r = r + (longint'(1) << i);
    return r;
  endfunction

  // n / sqrt(k) in fixed point
  function automatic logic signed [OUT_W-1:0] root_ratio_fx(longint n, longint k);
    longint m;
    longint t;
    longint q;
    m = n < 0 ? -n : n;
    t = (4 * m * m << (2 * FRAC_BITS)) / k;
    q = (root_floor(t) + 1) >> 1;
    return clamp_out(n < 0 ? -q : q);
  endfunction

  function automatic chans_t convert_pixel(logic [MODE_W-1:0] md, longint r, longint g,
                                           longint b);
    chans_t o;
    longint s, d1, d2, d3, r2, g2, b2;
    o = '{a: '0, b: '0, c: '0};
    case (md)
      MODE_PASS: begin
        o.a = ratio_fx(r, 1); o.b = ratio_fx(g, 1); o.c = ratio_fx(b, 1);
      end
      MODE_CHROMA: begin
        s = r + g + b;
        if (s == 0) s = 1;
        o.a = ratio_fx(r, s); o.b = ratio_fx(g, s); o.c = ratio_fx(b, s);
      end
      MODE_RGBII: begin
        o.a = ratio_fx(r, 1);
        o.b = ratio_fx(-5774 * r + 7887 * g - 2113 * b, 10000);
        o.c = ratio_fx(-5774 * r - 2113 * g + 7887 * b, 10000);
      end
      MODE_XYZII: begin
        o.a = ratio_fx(6070 * r + 1740 * g + 2000 * b, 10000);
        o.b = ratio_fx(-901 * r + 3631 * g - 2730 * b, 10000);
        o.c = ratio_fx(-4600 * r - 1986 * g + 6586 * b, 10000);
      end
      MODE_OPP: begin
        o.a = root_ratio_fx(r - g, 2);
        o.b = root_ratio_fx(r + g - 2 * b, 6);
        o.c = root_ratio_fx(r + g + b, 3);
      end
      MODE_I3: begin
        o.a = ratio_fx(r + g + b, 3);
        o.b = ratio_fx(r - b, 2);
        o.c = ratio_fx(2 * g - r - b, 2);
      end
      MODE_LSLM: begin
        r2 = 2 * r - 1; g2 = 2 * g - 1; b2 = 2 * b - 1;
        o.a = ratio_fx(209 * r2 + 715 * g2 + 76 * b2, 2000);
        o.b = ratio_fx(209 * r2 + 715 * g2 - 924 * b2, 2000);
        o.c = ratio_fx(3148 * r2 - 2799 * g2 - 349 * b2, 2000);
      end
      MODE_ZRG: begin
        o.a = ratio_fx(2018311 * r + 12955342 * g + 93918125 * b, 100000000);
        o.b = ratio_fx(r, 1);
        o.c = ratio_fx(g, 1);
      end
      MODE_L3: begin
        d1 = (r - g) * (r - g);
        d2 = (r - b) * (r - b);
        d3 = (g - b) * (g - b);
        s = d1 + d2 + d3;
        if (s == 0) s = 1;
        o.a = ratio_fx(d1, s); o.b = ratio_fx(d2, s); o.c = ratio_fx(d3, s);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void note_mismatch(string what, logic signed [OUT_W-1:0] exp_v,
                                        logic signed [OUT_W-1:0] got_v);
    if (errors < 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endfunction

  assign pending = expected_chans.size();

  always @(posedge clk) begin
    chans_t e;
    if (rst) begin
      cur_mode <= '0;
      errors   <= 0;
      results  <= 0;
      expected_chans.delete();
    end else begin
      if (start && !busy)
        expected_chans.push_back(convert_pixel(cur_mode, red, green, blue));
      if (cfg_valid && cfg_ready)
        cur_mode <= cfg_data;
      if (done) begin
        results <= results + 1;
        if (expected_chans.size() == 0) begin
          if (errors < 10) $display("%0t: result with no request outstanding", $realtime);
          errors++;
        end else begin
          e = expected_chans.pop_front();
          if (chan_a !== e.a) note_mismatch("chan_a", e.a, chan_a);
          if (chan_b !== e.b) note_mismatch("chan_b", e.b, chan_b);
          if (chan_c !== e.c) note_mismatch("chan_c", e.c, chan_c);
        end
      end
    end
  end

endmodule

FILE: bench/rgb_color_space_converter_unit_tb.sv
// Testbench top for the colour space converter: drives pixels and mode writes, gives the verdict.
module rgb_color_space_converter_unit_tb;
  import rcsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [IN_W-1:0]         red = '0, green = '0, blue = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [MODE_W-1:0]       cfg_data = '0;
  logic                    done;
  logic signed [OUT_W-1:0] chan_a, chan_b, chan_c;
  int                      errors, pending, results;
  int                      pixels_sent;
  logic [15:0]             modes_seen;

  always #5 clk = ~clk;

  rgb_color_space_converter_unit DUT (.*);

  rcsc_checker checker_i (.*);

  initial begin
    #2ms;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (CHAN_LAT + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] md);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = md;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    modes_seen[md] = 1'b1;
  endtask

  // called at a falling edge; returns at a falling edge with start still high
  task automatic send_pixel(logic [IN_W-1:0] r, logic [IN_W-1:0] g, logic [IN_W-1:0] b);
    start = 1'b1;
    red = r; green = g; blue = b;
    do @(posedge clk); while (busy);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic idle_gap(bit no_gaps);
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 65) return;
    n = roll < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_level();
    logic [IN_W-1:0] lv[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    return lv[$urandom_range(0, 3)];
  endfunction

  initial begin
    logic [IN_W-1:0] edges[11][3] = '{
      '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0},
      '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255},
      '{8'd255, 8'd0, 8'd255}, '{8'd1, 8'd254, 8'd128}, '{8'd200, 8'd200, 8'd200},
      '{8'd170, 8'd85, 8'd51}, '{8'd255, 8'd255, 8'd255}};
    logic [MODE_W-1:0] md;
    logic [IN_W-1:0]   r, g, b;
    int                count;
    bit                no_gaps;
    pixels_sent = 0;
    modes_seen  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: black and one edge pixel per mode, the last on the top mode
    for (int i = 0; i < 11; i++) begin
      md = i < 10 ? MODE_W'(i) : 4'd15;
      write_mode(md);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(edges[i][0], edges[i][1], edges[i][2]);
      start = 1'b0;
    end

    for (int p = 0; p < 20; p++) begin
      md      = p < 16 ? MODE_W'(p) : MODE_W'($urandom_range(0, 8));
      count   = md > MODE_L3 ? 15 : 60;
      no_gaps = ($urandom_range(0, 3) == 0);
      write_mode(md);
      for (int k = 0; k < count; k++) begin
        case ($urandom_range(0, 7))
          0: begin
            r = pick_level(); g = pick_level(); b = pick_level();
          end
          1: begin
            r = $urandom_range(0, 255); g = r; b = r;
          end
          default: begin
            r = $urandom_range(0, 255); g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
          end
        endcase
        send_pixel(r, g, b);
        if (p == 3 && k == 30) begin
          start = 1'b0;
          while (pending != 0) @(negedge clk);
        end else begin
          idle_gap(no_gaps);
        end
      end
      start = 1'b0;
    end

    while (pending != 0) @(posedge clk);
    repeat (CHAN_LAT + 10) @(posedge clk);
    $display("Sent %0d pixels, checked %0d results", pixels_sent, results);
    $display("Mode settings exercised (bit per mode): %b", modes_seen);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rcsc_pkg.sv
rtl/rcsc_front.sv
rtl/rcsc_queue.sv
rtl/rcsc_chan.sv
rtl/rgb_color_space_converter_unit.sv
bench/rcsc_checker.sv
bench/rgb_color_space_converter_unit_tb.sv
